// ===== rtl/tpg_pkg.sv =====
// Shared types and constants for the tach period to PWM gauge block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package tpg_pkg;

	// Width of the divider's dividend and quotient (ticks_per_second, 255 * rate)
	localparam int DVD_W = 16;
	localparam int TPS_W = 16;
	localparam int RL_W  = 8;
	localparam int DUTY_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [TPS_W-1:0]  TPS_RESET     = 16'd31250;
	localparam logic [RL_W-1:0]   REDLINE_RESET = 8'd141;
	localparam logic [DUTY_W-1:0] LEVEL_FULL    = 8'd255;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TPS     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDLINE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RATE,
		ST_LEVEL,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              load;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] red;
		logic              running;
	} res_t;

endpackage

// ===== rtl/tpg_ifs.sv =====
// Valid/ready channel interfaces for the gauge input items and result items.
// Depends on tpg_pkg for the duty width.
interface tpg_in_if;
	logic valid;
	logic ready;
	logic time_tick;
	logic ignition_pulse;

	modport source (output valid, output time_tick, output ignition_pulse, input ready);
	modport sink (input valid, input time_tick, input ignition_pulse, output ready);
endinterface

interface tpg_out_if;
	logic                      valid;
	logic                      ready;
	logic [tpg_pkg::DUTY_W-1:0] green_duty;
	logic [tpg_pkg::DUTY_W-1:0] red_duty;
	logic                      engine_running;

	modport source (output valid, output green_duty, output red_duty,
		output engine_running, input ready);
	modport sink (input valid, input green_duty, input red_duty,
		input engine_running, output ready);
endinterface

// ===== rtl/tpg_div.sv =====
// Shared restoring divider, one quotient bit per cycle, producing a DVD_W-bit quotient.
// Depends on tpg_pkg for the request and response structs.
module tpg_div #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tpg_pkg::div_req_t   req,
	input  logic [(COUNT_WIDTH > tpg_pkg::DVD_W ? COUNT_WIDTH : tpg_pkg::DVD_W)-1:0] divisor,
	output tpg_pkg::div_rsp_t   rsp
);

	localparam int DW = (COUNT_WIDTH > tpg_pkg::DVD_W) ? COUNT_WIDTH : tpg_pkg::DVD_W;
	localparam int STEP_W = $clog2(tpg_pkg::DVD_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tpg_pkg::DVD_W - 1);

	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         step_q;
	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             dsr_q;
	logic [tpg_pkg::DVD_W-1:0] quot_q;

	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic        fits;

	always_comb begin
		rem_sh  = {rem_q, quot_q[tpg_pkg::DVD_W-1]};
		fits    = (rem_sh >= {1'b0, dsr_q});
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift remainder and dividend left, bring in one quotient bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dsr_q  <= divisor;
			quot_q <= req.dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quot_q <= {quot_q[tpg_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// ===== rtl/tpg_ctrl.sv =====
// Tick counter, running flag, gauge levels and the sequencer that drives the divider.
// Depends on tpg_pkg for state, request, response and result types.
module tpg_ctrl #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         time_tick,
	input  logic                         ignition_pulse,
	output logic                         item_ready,
	input  logic [tpg_pkg::TPS_W-1:0]    tps,
	input  logic [tpg_pkg::RL_W-1:0]     redline,
	input  logic                         out_free,
	output tpg_pkg::div_req_t            div_req,
	output logic [(COUNT_WIDTH > tpg_pkg::DVD_W ? COUNT_WIDTH : tpg_pkg::DVD_W)-1:0] div_dsr,
	input  tpg_pkg::div_rsp_t            div_rsp,
	output tpg_pkg::res_t                res
);

	localparam int DW = (COUNT_WIDTH > tpg_pkg::DVD_W) ? COUNT_WIDTH : tpg_pkg::DVD_W;

	tpg_pkg::state_t state_q, state_nx;

	logic [COUNT_WIDTH-1:0]     count_q;
	logic                       running_q;
	logic [tpg_pkg::DUTY_W-1:0] red_q;
	logic [tpg_pkg::DUTY_W-1:0] green_q;

	logic                       accept;
	logic [COUNT_WIDTH-1:0]     count_tk;
	logic [DW-1:0]              tps_ext;
	logic                       timeout;
	logic                       full_red;
	logic                       rate_clamp;
	logic [tpg_pkg::DUTY_W-1:0] rate_lo;
	logic [tpg_pkg::DVD_W-1:0]  scaled;

	always_comb begin
		accept   = item_valid && (state_q == tpg_pkg::ST_IDLE);
		tps_ext  = DW'(tps);
		count_tk = count_q;
		if (time_tick && (DW'(count_q) < tps_ext) && (count_q != '1))
			count_tk = count_q + 1'b1;
		timeout  = running_q && (DW'(count_tk) >= tps_ext);
		// zero redline or zero count both mean full red, no division needed
		full_red = (redline == '0) || (count_tk == '0);
		rate_clamp = (div_rsp.quotient >= tpg_pkg::DVD_W'(redline));
		rate_lo  = div_rsp.quotient[tpg_pkg::DUTY_W-1:0];
		// 255 * rate as (rate << 8) - rate
		scaled   = {rate_lo, 8'd0} - {8'd0, rate_lo};
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tpg_pkg::ST_IDLE: begin
				if (accept)
					state_nx = (ignition_pulse && !full_red) ? tpg_pkg::ST_RATE
						: tpg_pkg::ST_HOLD;
			end
			tpg_pkg::ST_RATE: begin
				if (div_rsp.done)
					state_nx = rate_clamp ? tpg_pkg::ST_HOLD : tpg_pkg::ST_LEVEL;
			end
			tpg_pkg::ST_LEVEL: begin
				if (div_rsp.done)
					state_nx = tpg_pkg::ST_HOLD;
			end
			tpg_pkg::ST_HOLD: begin
				if (out_free)
					state_nx = tpg_pkg::ST_IDLE;
			end
			default: state_nx = tpg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == tpg_pkg::ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = tps;
		div_dsr          = DW'(count_tk);
		case (state_q)
			tpg_pkg::ST_IDLE: begin
				div_req.start = accept && ignition_pulse && !full_red;
			end
			tpg_pkg::ST_RATE: begin
				div_req.start    = div_rsp.done && !rate_clamp;
				div_req.dividend = scaled;
				div_dsr          = DW'(redline);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
		res.load    = (state_q == tpg_pkg::ST_HOLD) && out_free;
		res.green   = green_q;
		res.red     = red_q;
		res.running = running_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tpg_pkg::ST_IDLE;
			count_q   <= '0;
			running_q <= 1'b0;
			red_q     <= '0;
			green_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				if (ignition_pulse) begin
					count_q   <= '0;
					running_q <= 1'b1;
					if (full_red) begin
						red_q   <= tpg_pkg::LEVEL_FULL;
						green_q <= '0;
					end
				end else begin
					count_q <= count_tk;
					if (timeout) begin
						running_q <= 1'b0;
						red_q     <= '0;
						green_q   <= '0;
					end
				end
			end
			if (state_q == tpg_pkg::ST_RATE && div_rsp.done && rate_clamp) begin
				red_q   <= tpg_pkg::LEVEL_FULL;
				green_q <= '0;
			end
			if (state_q == tpg_pkg::ST_LEVEL && div_rsp.done) begin
				red_q   <= rate_lo;
				green_q <= tpg_pkg::LEVEL_FULL - rate_lo;
			end
		end
	end

endmodule

// ===== rtl/tach_period_to_pwm_gauge_unit.sv =====
// Top level of the tach period to PWM gauge: configuration registers and result register.
// Depends on tpg_pkg, tpg_ifs, tpg_div and tpg_ctrl.
//
//  channel | direction | payload                                   | handshake
//  item    | in        | time_tick, ignition_pulse                 | valid/ready
//  result  | out       | green_duty, red_duty, engine_running      | valid/ready
//  cfg     | in        | cfg_index, cfg_wdata                      | cfg_we only
//
// A transaction without an ignition pulse goes from idle straight to the hold state. A pulse
// transaction makes two passes through the shared bit-serial divider (rate, then gauge
// level) before the hold state; a zero count, zero redline or clamped rate skips
// one or both passes. Reset clears the count, running flag and duties and loads the
// register defaults. A stalled result holds in the result register; the next
// transaction is taken while it waits, and its result waits in the sequencer.
module tach_period_to_pwm_gauge_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpg_pkg::TPS_W-1:0]        cfg_wdata,
	tpg_in_if.sink                           item,
	tpg_out_if.source                        result
);

	localparam int DW = (COUNT_WIDTH > tpg_pkg::DVD_W) ? COUNT_WIDTH : tpg_pkg::DVD_W;

	logic [tpg_pkg::TPS_W-1:0]  tps_q;
	logic [tpg_pkg::RL_W-1:0]   redline_q;

	logic                       out_valid_q;
	logic [tpg_pkg::DUTY_W-1:0] green_q;
	logic [tpg_pkg::DUTY_W-1:0] red_q;
	logic                       running_q;

	logic                       out_free;
	logic                       item_ready;
	tpg_pkg::div_req_t          div_req;
	tpg_pkg::div_rsp_t          div_rsp;
	logic [DW-1:0]              div_dsr;
	tpg_pkg::res_t              res;

	// Load the register that the index selects on each write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q     <= tpg_pkg::TPS_RESET;
			redline_q <= tpg_pkg::REDLINE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tpg_pkg::CFG_TPS:     tps_q     <= cfg_wdata;
				tpg_pkg::CFG_REDLINE: redline_q <= cfg_wdata[tpg_pkg::RL_W-1:0];
				default: ;
			endcase
		end
	end

	// The result slot frees when empty or when its transaction completes this cycle.
	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = item_ready;

	tpg_ctrl #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item.valid),
		.time_tick      (item.time_tick),
		.ignition_pulse (item.ignition_pulse),
		.item_ready     (item_ready),
		.tps            (tps_q),
		.redline        (redline_q),
		.out_free       (out_free),
		.div_req        (div_req),
		.div_dsr        (div_dsr),
		.div_rsp        (div_rsp),
		.res            (res)
	);

	tpg_div #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (div_dsr),
		.rsp     (div_rsp)
	);

	// Result register: load on a finished transaction, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			green_q   <= res.green;
			red_q     <= res.red;
			running_q <= res.running;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.green_duty     = green_q;
	assign result.red_duty       = red_q;
	assign result.engine_running = running_q;

endmodule

// ===== rtl/tpg_checker.sv =====
// Port-level checks for the tach period to PWM gauge, attached to the top level by bind.
// Depends on tpg_pkg for field widths.
module tpg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             in_pulse,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [tpg_pkg::DUTY_W-1:0]       green_duty,
	input logic [tpg_pkg::DUTY_W-1:0]       red_duty,
	input logic                             engine_running
);

	// A pulse transaction starts a division unless the count or redline is zero; no new transaction the next cycle.
	a_busy_after_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_pulse) |=> !in_ready)
		else $error("input ready right after a pulse transaction");

	// Duties split the full scale while running, and are both zero when stopped.
	a_duty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((engine_running
			&& ({1'b0, red_duty} + {1'b0, green_duty}) == 9'd255)
		|| (!engine_running && red_duty == '0 && green_duty == '0)))
		else $error("green and red duties inconsistent with running flag");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(green_duty) && $stable(red_duty)
			&& $stable(engine_running)))
		else $error("result payload changed while stalled");

endmodule

bind tach_period_to_pwm_gauge_unit tpg_checker u_tpg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.in_pulse       (item.ignition_pulse),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.green_duty     (result.green_duty),
	.red_duty       (result.red_duty),
	.engine_running (result.engine_running)
);
